// ----- rtl/core/jtlse_pkg.sv -----
`default_nettype none
package jtlse_pkg;

    localparam int KeyMax    = 16;
    localparam int WinLen    = KeyMax + 2;
    localparam int LenBits   = 5;
    localparam int DepthBits = 8;
    localparam int FifoDepth = 4;
    localparam int PtrBits   = 2;
    localparam int CntBits   = PtrBits + 1;

    typedef enum logic [2:0] {
        KIND_BYTE     = 3'd0,
        KIND_FOUND    = 3'd1,
        KIND_NOTFOUND = 3'd2,
        KIND_NOTSTR   = 3'd3,
        KIND_UNTERM   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_KEY_LEN = 2'd0,
        REG_KEY_LO  = 2'd1,
        REG_KEY_HI  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value_byte;
        logic       run_end;
    } result_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;

endpackage
`default_nettype wire

// ----- rtl/core/jtlse_res_fifo.sv -----
`default_nettype none
module jtlse_res_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [1:0]          push_cnt,
    input  wire jtlse_pkg::result_t  push_a,
    input  wire jtlse_pkg::result_t  push_b,
    output logic                     room_ok,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output jtlse_pkg::result_t       m_data
);

    jtlse_pkg::result_t                  mem_reg [jtlse_pkg::FifoDepth];
    logic [jtlse_pkg::PtrBits-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [jtlse_pkg::PtrBits-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [jtlse_pkg::CntBits-1:0]       cnt_reg, cnt_next;
    logic                                pop;
    logic [jtlse_pkg::PtrBits-1:0]       wr_ptr_inc;

    assign m_valid    = (cnt_reg != '0);
    assign m_data     = mem_reg[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign room_ok    = (cnt_reg <= jtlse_pkg::CntBits'(jtlse_pkg::FifoDepth - 2));
    assign wr_ptr_inc = wr_ptr_reg + jtlse_pkg::PtrBits'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + jtlse_pkg::PtrBits'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + jtlse_pkg::PtrBits'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + jtlse_pkg::CntBits'(push_cnt)
                      - jtlse_pkg::CntBits'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push_b;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/json_top_level_string_extract.sv -----
`default_nettype none
// A result is written to the output queue as its document byte is accepted; m_ offers it.
// One document byte per cycle while s_tready is high; the key window compare and state
// update are combinational. A last byte may give two results (value byte, then status).
// s_tready drops while more than two results wait in the 4-entry output queue.
// Reset (aresetn low, synchronous) clears scan state, key_length to 1, key bytes to 0.
module json_top_level_string_extract (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // doc_byte
    input  wire logic        s_tlast,   // doc_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // value_byte
    output logic [2:0]       m_tuser,   // kind
    output logic             m_tlast,   // run_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int KeyMax = jtlse_pkg::KeyMax;
    localparam int WinLen = jtlse_pkg::WinLen;
    localparam int DBits  = jtlse_pkg::DepthBits;
    localparam logic signed [DBits-1:0] DepthMax = {1'b0, {(DBits-1){1'b1}}};
    localparam logic signed [DBits-1:0] DepthMin = {1'b1, {(DBits-1){1'b0}}};
    localparam logic signed [DBits-1:0] DepthOne = DBits'(1);

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_BLANKS,
        PH_VALUE,
        PH_ESCAPE,
        PH_DONE
    } phase_t;

    logic [jtlse_pkg::LenBits-1:0] key_len_reg;
    logic [63:0]                   key_lo_reg;
    logic [63:0]                   key_hi_reg;

    logic [7:0]              win_reg  [WinLen];
    logic [7:0]              win_next [WinLen];
    logic [WinLen-1:0]       elig_reg, elig_next;
    logic                    instr_reg, instr_next;
    logic                    esc_reg, esc_next;
    logic signed [DBits-1:0] depth_reg, depth_next;
    phase_t                  phase_reg, phase_next;

    logic                          accept;
    logic                          cfg_wr;
    logic                          room_ok;
    logic [1:0]                    push_cnt;
    jtlse_pkg::result_t            res_a, res_b, out_res;
    logic [127:0]                  key_all;
    logic [jtlse_pkg::LenBits-1:0] len_sat;
    logic [KeyMax:0]               len_hit;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = room_ok;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign key_all  = {key_hi_reg, key_lo_reg};
    assign len_sat  = (key_len_reg > jtlse_pkg::LenBits'(KeyMax))
                      ? jtlse_pkg::LenBits'(KeyMax) : key_len_reg;

    always_comb begin
        case (jtlse_pkg::reg_idx_t'(paddr[4:3]))
            jtlse_pkg::REG_KEY_LEN: prdata = {59'd0, key_len_reg};
            jtlse_pkg::REG_KEY_LO:  prdata = key_lo_reg;
            jtlse_pkg::REG_KEY_HI:  prdata = key_hi_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= jtlse_pkg::LenBits'(1);
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
        end else if (cfg_wr) begin
            case (jtlse_pkg::reg_idx_t'(paddr[4:3]))
                jtlse_pkg::REG_KEY_LEN: key_len_reg <= pwdata[jtlse_pkg::LenBits-1:0];
                jtlse_pkg::REG_KEY_LO:  key_lo_reg  <= pwdata;
                jtlse_pkg::REG_KEY_HI:  key_hi_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // quoted key candidate of each length ending just before the current byte
    always_comb begin
        logic ok;
        len_hit = '0;
        for (int l = 0; l <= KeyMax; l++) begin
            ok = (win_reg[0] == jtlse_pkg::CH_QUOTE) &&
                 (win_reg[l+1] == jtlse_pkg::CH_QUOTE) && elig_reg[l+1];
            for (int j = 0; j < l; j++) begin
                if (win_reg[l-j] != key_all[8*j +: 8]) begin
                    ok = 1'b0;
                end
            end
            len_hit[l] = ok;
        end
    end

    always_comb begin
        logic [7:0] c;
        logic       last;
        logic       hit;
        logic       blank;
        c     = s_tdata;
        last  = s_tlast;
        hit   = (c == jtlse_pkg::CH_COLON) && len_hit[len_sat];
        blank = (c == jtlse_pkg::CH_SPACE) || (c == jtlse_pkg::CH_TAB) ||
                (c == jtlse_pkg::CH_CR) || (c == jtlse_pkg::CH_LF);

        win_next   = win_reg;
        elig_next  = elig_reg;
        instr_next = instr_reg;
        esc_next   = esc_reg;
        depth_next = depth_reg;
        phase_next = phase_reg;
        push_cnt   = 2'd0;
        res_a      = '{kind: jtlse_pkg::KIND_BYTE, value_byte: 8'd0, run_end: 1'b0};
        res_b      = '{kind: jtlse_pkg::KIND_UNTERM, value_byte: 8'd0, run_end: 1'b1};

        case (phase_reg)
            PH_SEARCH: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (instr_reg) begin
                    if (c == jtlse_pkg::CH_BSLASH) begin
                        esc_next = 1'b1;
                    end else if (c == jtlse_pkg::CH_QUOTE) begin
                        instr_next = 1'b0;
                    end
                end else if (c == jtlse_pkg::CH_QUOTE) begin
                    instr_next = 1'b1;
                end else if (c == jtlse_pkg::CH_LBRACE || c == jtlse_pkg::CH_LBRACK) begin
                    if (depth_reg < DepthMax) begin
                        depth_next = depth_reg + DepthOne;
                    end
                end else if (c == jtlse_pkg::CH_RBRACE || c == jtlse_pkg::CH_RBRACK) begin
                    if (depth_reg > DepthMin) begin
                        depth_next = depth_reg - DepthOne;
                    end
                end
                for (int i = 1; i < WinLen; i++) begin
                    win_next[i] = win_reg[i-1];
                end
                win_next[0]  = c;
                elig_next    = {elig_reg[WinLen-2:0], !instr_reg && (depth_reg <= DepthOne)};
                if (hit) begin
                    phase_next = PH_BLANKS;
                    if (last) begin
                        push_cnt   = 2'd1;
                        res_a.kind = jtlse_pkg::KIND_NOTSTR;
                        res_a.run_end = 1'b1;
                    end
                end else if (last) begin
                    push_cnt      = 2'd1;
                    res_a.kind    = jtlse_pkg::KIND_NOTFOUND;
                    res_a.run_end = 1'b1;
                end
            end
            PH_BLANKS: begin
                if (blank) begin
                    if (last) begin
                        push_cnt      = 2'd1;
                        res_a.kind    = jtlse_pkg::KIND_NOTSTR;
                        res_a.run_end = 1'b1;
                    end
                end else if (c == jtlse_pkg::CH_QUOTE) begin
                    phase_next = PH_VALUE;
                    if (last) begin
                        push_cnt      = 2'd1;
                        res_a.kind    = jtlse_pkg::KIND_UNTERM;
                        res_a.run_end = 1'b1;
                    end
                end else begin
                    push_cnt      = 2'd1;
                    res_a.kind    = jtlse_pkg::KIND_NOTSTR;
                    res_a.run_end = 1'b1;
                    phase_next    = PH_DONE;
                end
            end
            PH_VALUE: begin
                if (c == jtlse_pkg::CH_QUOTE) begin
                    push_cnt      = 2'd1;
                    res_a.kind    = jtlse_pkg::KIND_FOUND;
                    res_a.run_end = 1'b1;
                    phase_next    = PH_DONE;
                end else if (c == jtlse_pkg::CH_BSLASH) begin
                    phase_next = PH_ESCAPE;
                    if (last) begin
                        push_cnt      = 2'd1;
                        res_a.kind    = jtlse_pkg::KIND_UNTERM;
                        res_a.run_end = 1'b1;
                    end
                end else begin
                    res_a.value_byte = c;
                    push_cnt         = last ? 2'd2 : 2'd1;
                end
            end
            PH_ESCAPE: begin
                res_a.value_byte = c;
                push_cnt         = last ? 2'd2 : 2'd1;
                phase_next       = PH_VALUE;
            end
            default: ;
        endcase

        if (last) begin
            for (int i = 0; i < WinLen; i++) begin
                win_next[i] = 8'd0;
            end
            elig_next  = '0;
            instr_next = 1'b0;
            esc_next   = 1'b0;
            depth_next = '0;
            phase_next = PH_SEARCH;
        end

        if (!accept) begin
            push_cnt = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WinLen; i++) begin
                win_reg[i] <= 8'd0;
            end
            elig_reg  <= '0;
            instr_reg <= 1'b0;
            esc_reg   <= 1'b0;
            depth_reg <= '0;
            phase_reg <= PH_SEARCH;
        end else if (accept) begin
            win_reg   <= win_next;
            elig_reg  <= elig_next;
            instr_reg <= instr_next;
            esc_reg   <= esc_next;
            depth_reg <= depth_next;
            phase_reg <= phase_next;
        end
    end

    jtlse_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_a   (res_a),
        .push_b   (res_b),
        .room_ok  (room_ok),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (out_res)
    );

    assign m_tdata = out_res.value_byte;
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.run_end;

endmodule
`default_nettype wire
